### src/crlfrx_pkg.sv
// ----------------------------------------------------------------------------
// crlfrx_pkg
// Shared types and constants for the CR/LF delimited frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crlfrx_pkg;

    // frame buffer depth, bounds the stored byte count
    localparam int BUF_DEPTH = 512;

    // width used for the limit compare, covers any buffer depth up to 4096
    localparam int LIM_W = 13;

    // delimiter characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // configuration register map
    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;
    localparam logic [9:0] MAX_LENGTH_RESET = 10'd500;

    // state word kept in the state memory
    localparam int STATE_DEPTH = 2;
    localparam logic [0:0] STATE_ADDR = 1'b0;

    typedef struct packed {
        logic [15:0] frame_counter;
        logic [9:0]  fill_count;
        logic        cr_armed;
        logic        last_was_lf;
        logic        in_frame;
    } crlfrx_state_t;

    localparam int STATE_W = $bits(crlfrx_state_t);

    // one result item
    typedef struct packed {
        logic        store_valid;
        logic [8:0]  store_index;
        logic [7:0]  store_byte;
        logic        frame_done;
        logic [9:0]  frame_length;
        logic        overflow;
        logic [15:0] frames_seen;
    } crlfrx_result_t;

endpackage : crlfrx_pkg

`default_nettype wire

### src/crlfrx_ram.sv
// ----------------------------------------------------------------------------
// crlfrx_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module crlfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : crlfrx_ram

`default_nettype wire

### src/crlfrx_cfg.sv
// ----------------------------------------------------------------------------
// crlfrx_cfg
// APB register slave holding the max_length register.
// ----------------------------------------------------------------------------
`default_nettype none

module crlfrx_cfg
    import crlfrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [9:0]  max_length
);

    logic [9:0] max_length_reg;
    logic       wr_en;

    assign pready = 1'b1;

    // word-aligned decode, low address bits ignored
    assign wr_en = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            max_length_reg <= pwdata[9:0];
        end
    end

    // read mux
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_LENGTH)
        begin
            prdata = {22'd0, max_length_reg};
        end
    end

    assign max_length = max_length_reg;

endmodule : crlfrx_cfg

`default_nettype wire

### src/crlfrx_update.sv
// ----------------------------------------------------------------------------
// crlfrx_update
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crlfrx_update
    import crlfrx_pkg::*;
(
    input  wire crlfrx_state_t  cur_state,
    input  wire logic [7:0]     rx_byte,
    input  wire logic [9:0]     max_length,
    output crlfrx_state_t       next_state,
    output crlfrx_result_t      result
);

    localparam logic [LIM_W-1:0] BUF_LIM = LIM_W'(BUF_DEPTH);

    logic [LIM_W-1:0] max_ext;
    logic [LIM_W-1:0] limit;
    logic [9:0]       fill_inc;
    logic             closing;
    logic             is_cr;
    logic             is_lf;

    // effective limit is the smaller of max_length and the buffer depth
    assign max_ext  = {{(LIM_W-10){1'b0}}, max_length};
    assign limit    = (max_ext > BUF_LIM) ? BUF_LIM : max_ext;
    assign fill_inc = cur_state.fill_count + 10'd1;
    assign is_cr    = (rx_byte == CH_CR);
    assign is_lf    = (rx_byte == CH_LF);
    assign closing  = cur_state.last_was_lf && is_cr;

    always_comb
    begin
        next_state = cur_state;
        result     = '0;

        if (cur_state.in_frame)
        begin
            if (closing)
            begin
                // LF then CR closes the frame, CR not stored
                result.frame_done        = 1'b1;
                result.frame_length      = cur_state.fill_count;
                next_state.frame_counter = cur_state.frame_counter + 16'd1;
                next_state.fill_count    = 10'd0;
                next_state.in_frame      = 1'b0;
                next_state.last_was_lf   = 1'b0;
                next_state.cr_armed      = 1'b0;
            end
            else
            begin
                // store the byte at the current fill position
                result.store_valid     = 1'b1;
                result.store_index     = cur_state.fill_count[8:0];
                result.store_byte      = rx_byte;
                next_state.fill_count  = fill_inc;
                next_state.cr_armed    = 1'b0;
                next_state.last_was_lf = is_lf;
                // drop the frame once the limit is reached
                if ({{(LIM_W-10){1'b0}}, fill_inc} >= limit)
                begin
                    result.overflow       = 1'b1;
                    next_state.fill_count = 10'd0;
                    next_state.in_frame   = 1'b0;
                end
            end
        end
        else
        begin
            // idle: CR arms, LF while armed opens a frame
            if (is_cr)
            begin
                next_state.cr_armed = 1'b1;
            end
            else if (is_lf && cur_state.cr_armed)
            begin
                next_state.in_frame    = 1'b1;
                next_state.last_was_lf = 1'b0;
                next_state.cr_armed    = 1'b0;
            end
        end

        result.frames_seen = next_state.frame_counter;
    end

endmodule : crlfrx_update

`default_nettype wire

### src/crlf_delimited_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// crlf_delimited_frame_receiver_unit
// CR/LF delimited frame receiver: one byte in, one store/done/overflow item out.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake               | payload
//   s_*      | in  | s_tvalid / s_tready     | s_tdata: rx_byte
//   m_*      | out | m_tvalid / m_tready     | m_tdata, m_tlast, m_tuser
//   apb      | in  | psel & penable & pwrite | max_length at byte address 0
//
// One item per cycle sustained unless m_tready stalls; an item passes the
// compute stage register, then the output register. The receiver state lives in
// one word of a registered-read RAM, read when an item is taken and written back
// when the compute stage fires; a back-to-back item takes the written-back word
// through a forwarding register instead of the RAM. Reset clears control flops;
// the state word reads as zero until first written. A stall on m_tready holds the
// output register and the compute stage, then drops s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_delimited_frame_receiver_unit
    import crlfrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [8:0] store_index, [16:9] store_byte,
                                        // [26:17] frame_length, [42:27] frames_seen
    output logic             m_tlast,   // frame_done
    output logic      [1:0]  m_tuser,   // [0] store_valid, [1] overflow
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [9:0]     max_length;
    logic           s_fire;
    logic           s1_fire;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [7:0]     s1_byte_reg;
    logic           s1_fwd_reg;
    crlfrx_state_t  s1_fwd_state_reg;
    logic           s1_init_reg;
    logic           state_written_reg;

    logic [STATE_W-1:0] ram_rdata;
    crlfrx_state_t  cur_state;
    crlfrx_state_t  next_state;
    crlfrx_result_t result;

    logic           o_valid_reg;
    crlfrx_result_t o_result_reg;

    // configuration registers
    crlfrx_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    // handshakes
    assign s1_fire  = s1_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    // state memory: read on accept, write back when the compute stage fires
    crlfrx_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (STATE_ADDR),
        .wdata (next_state),
        .re    (s_fire),
        .raddr (STATE_ADDR),
        .rdata (ram_rdata)
    );

    // pick forwarded word, RAM word, or the reset value
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            cur_state = s1_fwd_state_reg;
        end
        else if (s1_init_reg)
        begin
            cur_state = crlfrx_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = '0;
        end
    end

    crlfrx_update u_update (
        .cur_state  (cur_state),
        .rx_byte    (s1_byte_reg),
        .max_length (max_length),
        .next_state (next_state),
        .result     (result)
    );

    // compute stage control
    assign s1_valid_next = s_fire || (s1_valid_reg && !s1_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s1_fwd_reg        <= 1'b0;
            s1_init_reg       <= 1'b0;
            state_written_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s_fire)
            begin
                // a write-back in the read cycle is not seen by the RAM read
                s1_fwd_reg  <= s1_fire;
                s1_init_reg <= state_written_reg;
            end
            if (s1_fire)
            begin
                state_written_reg <= 1'b1;
            end
        end
    end

    // compute stage payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_byte_reg      <= s_tdata;
            s1_fwd_state_reg <= next_state;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            o_result_reg <= result;
        end
    end

    // output packing
    assign m_tvalid = o_valid_reg;
    assign m_tlast  = o_result_reg.frame_done;
    assign m_tuser  = {o_result_reg.overflow, o_result_reg.store_valid};
    assign m_tdata  = {5'd0,
                       o_result_reg.frames_seen,
                       o_result_reg.frame_length,
                       o_result_reg.store_byte,
                       o_result_reg.store_index};

endmodule : crlf_delimited_frame_receiver_unit

`default_nettype wire

### src/crlfrx_checker.sv
// ----------------------------------------------------------------------------
// crlfrx_checker
// Port-level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crlfrx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // a closing item stores nothing and raises no overflow
    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == 2'b00)
        else $error("frame done together with store or overflow");

    // overflow only on a stored byte
    a_ovf_store: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("overflow without a stored byte");

    // no store: index and byte are zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[16:0] == 17'd0)
        else $error("store fields set without a store");

    // length is reported only with frame done
    a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[26:17] == 10'd0)
        else $error("frame length set without frame done");

endmodule : crlfrx_checker

bind crlf_delimited_frame_receiver_unit crlfrx_checker u_crlfrx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
